>>> design/arp_responder_with_aging_cache_core_assert.svh
// Assertion macros for the ARP responder core.
`ifndef ARP_RESPONDER_WITH_AGING_CACHE_CORE_ASSERT_SVH
`define ARP_RESPONDER_WITH_AGING_CACHE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled during reset.
`define ARPC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ARPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ARPC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ARPC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> design/arpc_pkg.sv
// Shared types and constants for the ARP responder core.
`default_nettype none

package arpc_pkg;

    localparam int CACHE_ENTRIES = 16;

    localparam logic [15:0] ETH_IPV4_TYPE = 16'h0800;
    localparam logic [7:0]  MAC_BYTES     = 8'd6;
    localparam logic [15:0] OP_REQUEST    = 16'd1;

    // item kinds
    localparam logic [1:0] KIND_PACKET = 2'd0;
    localparam logic [1:0] KIND_LOOKUP = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_LOCAL_IP  = 2'd0;
    localparam logic [1:0] CFG_LOCAL_MAC = 2'd1;
    localparam logic [1:0] CFG_AGE_LIMIT = 2'd2;

    localparam logic [31:0] AGE_LIMIT_RESET = 32'd300;

    typedef enum logic [1:0] {
        WALK_NONE   = 2'd0,
        WALK_LEARN  = 2'd1,
        WALK_LOOKUP = 2'd2
    } walk_op_t;

    // broadcast to every cell, constant for one walk
    typedef struct packed {
        walk_op_t    op;
        logic [31:0] key_ip;
        logic [47:0] key_mac;
        logic [31:0] now;
        logic [31:0] age_limit;
        logic        commit;
    } cell_cmd_t;

    // walk token handed from cell to cell
    typedef struct packed {
        logic        active;
        logic        found;
        logic        free_seen;
        logic [47:0] mac;
    } cell_tok_t;

endpackage

`default_nettype wire

>>> design/arpc_cell.sv
// One cache entry of the ARP cache chain.
`default_nettype none

module arpc_cell import arpc_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire cell_cmd_t cmd,
    input  wire cell_tok_t tok_in,
    output cell_tok_t      tok_out
);

    logic        valid_reg, valid_next;
    logic        claim_reg, claim_next;
    logic [31:0] ip_reg, ip_next;
    logic [47:0] mac_reg, mac_next;
    logic [31:0] stamp_reg, stamp_next;
    cell_tok_t   tok_reg, tok_next;

    logic [31:0] age;
    logic        stale;
    logic        match;

    assign age   = cmd.now - stamp_reg;
    assign stale = age > cmd.age_limit;
    assign match = valid_reg && (ip_reg == cmd.key_ip);

    always_comb begin
        valid_next = valid_reg;
        claim_next = claim_reg;
        ip_next    = ip_reg;
        mac_next   = mac_reg;
        stamp_next = stamp_reg;
        tok_next   = tok_in;

        if (tok_in.active) begin
            claim_next = 1'b0;
            case (cmd.op)
                WALK_LOOKUP: begin
                    if (valid_reg && stale) begin
                        valid_next = 1'b0;
                    end else if (match && !tok_in.found) begin
                        stamp_next     = cmd.now;
                        tok_next.found = 1'b1;
                        tok_next.mac   = mac_reg;
                    end
                end
                WALK_LEARN: begin
                    if (match && !tok_in.found) begin
                        mac_next       = cmd.key_mac;
                        stamp_next     = cmd.now;
                        tok_next.found = 1'b1;
                    end
                    // lowest free slot is claimed, committed at walk end
                    if (!valid_reg && !tok_in.free_seen) begin
                        claim_next         = 1'b1;
                        tok_next.free_seen = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end else if (cmd.commit && claim_reg) begin
            valid_next = 1'b1;
            claim_next = 1'b0;
            ip_next    = cmd.key_ip;
            mac_next   = cmd.key_mac;
            stamp_next = cmd.now;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            claim_reg <= 1'b0;
            tok_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            claim_reg <= claim_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        ip_reg    <= ip_next;
        mac_reg   <= mac_next;
        stamp_reg <= stamp_next;
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

>>> design/arpc_chain.sv
// Row of cache cells that the walk token travels through.
`default_nettype none

module arpc_chain import arpc_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire cell_cmd_t cmd,
    input  wire cell_tok_t tok_first,
    output cell_tok_t      tok_last
);

    cell_tok_t tok [0:CACHE_ENTRIES];

    assign tok[0] = tok_first;

    for (genvar g = 0; g < CACHE_ENTRIES; g++) begin : g_cell
        arpc_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cmd     (cmd),
            .tok_in  (tok[g]),
            .tok_out (tok[g + 1])
        );
    end

    assign tok_last = tok[CACHE_ENTRIES];

endmodule

`default_nettype wire

>>> design/arp_responder_with_aging_cache_core.sv
// Top level of the ARP responder with aging IPv4-to-MAC cache.
//
// ARP responder with an aging cache. Each request on the s_ channel is an
// ARP packet, a cache lookup or one time tick, and gives exactly one result
// on the m_ channel. The cache is a row of CACHE_ENTRIES cells; a packet that
// learns (IPv4, hardware length 6) or a lookup sends a token down the row,
// one cell per cycle; when the token leaves the last cell the block moves to
// its finish state and writes the result once the result register is free.
// Packets that do not learn, ticks and unknown kinds skip the walk and go
// straight to the finish state. One request is in work at a time; the result
// register lets a new request in while the previous result waits. A lookup
// expires every entry older than age_limit ticks and refreshes the first
// live match. Learning updates the first valid entry with the same IP,
// otherwise takes the lowest free slot; with no free slot learn_dropped is
// set. Expired entries not yet removed by a lookup still occupy a slot.
// Configuration writes are taken at any time but must only be issued while
// the block is idle. local_mac is held for the reply builder downstream.
`default_nettype none

module arp_responder_with_aging_cache_core import arpc_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // configuration write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [47:0] cfg_wdata,

    // request channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_kind,
    input  wire logic [15:0] s_opcode,
    input  wire logic [15:0] s_proto_type,
    input  wire logic [7:0]  s_hw_len,
    input  wire logic [31:0] s_src_ip,
    input  wire logic [47:0] s_src_mac,
    input  wire logic [31:0] s_tgt_ip,
    input  wire logic [7:0]  s_in_port,
    input  wire logic [31:0] s_query_ip,

    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_reply_valid,
    output logic [47:0]      m_reply_dst_mac,
    output logic [31:0]      m_reply_dst_ip,
    output logic [7:0]       m_reply_port,
    output logic             m_lookup_hit,
    output logic [47:0]      m_hit_mac,
    output logic             m_learn_dropped
);

`include "arp_responder_with_aging_cache_core_assert.svh"

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [31:0] local_ip_reg;
    logic [47:0] local_mac_reg;
    logic [31:0] age_limit_reg;

    logic [31:0] tick_count_reg;

    // latched request
    logic [1:0]  kind_reg;
    logic [15:0] opcode_reg;
    logic [31:0] src_ip_reg;
    logic [47:0] src_mac_reg;
    logic [31:0] tgt_ip_reg;
    logic [7:0]  port_reg;
    logic [31:0] key_ip_reg;
    walk_op_t    walk_op_reg;
    logic        inject_reg;

    // walk outcome
    logic        found_reg;
    logic        free_seen_reg;
    logic [47:0] found_mac_reg;

    // result register
    logic        m_valid_reg;
    logic        reply_valid_reg;
    logic [47:0] reply_dst_mac_reg;
    logic [31:0] reply_dst_ip_reg;
    logic [7:0]  reply_port_reg;
    logic        lookup_hit_reg;
    logic [47:0] hit_mac_reg;
    logic        learn_dropped_reg;

    logic      in_fire;
    logic      fin_go;
    logic      tick_go;
    logic      hit_out;
    logic      do_learn;
    walk_op_t  walk_op_in;
    logic      reply_now;
    cell_cmd_t cmd;
    cell_tok_t tok_first;
    cell_tok_t tok_last;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_fire   = s_valid && s_ready;
    assign fin_go    = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);
    assign tick_go   = fin_go && (kind_reg == KIND_TICK);

    assign do_learn = (s_kind == KIND_PACKET) && (s_proto_type == ETH_IPV4_TYPE)
                      && (s_hw_len == MAC_BYTES);

    always_comb begin
        if (do_learn) begin
            walk_op_in = WALK_LEARN;
        end else if (s_kind == KIND_LOOKUP) begin
            walk_op_in = WALK_LOOKUP;
        end else begin
            walk_op_in = WALK_NONE;
        end
    end

    assign reply_now = (kind_reg == KIND_PACKET) && (opcode_reg == OP_REQUEST)
                       && (tgt_ip_reg == local_ip_reg);

    // broadcast to the cell row; commit writes the claimed free slot
    assign cmd.op        = walk_op_reg;
    assign cmd.key_ip    = key_ip_reg;
    assign cmd.key_mac   = src_mac_reg;
    assign cmd.now       = tick_count_reg;
    assign cmd.age_limit = age_limit_reg;
    assign cmd.commit    = fin_go && (walk_op_reg == WALK_LEARN)
                           && !found_reg && free_seen_reg;

    assign tok_first.active    = inject_reg;
    assign tok_first.found     = 1'b0;
    assign tok_first.free_seen = 1'b0;
    assign tok_first.mac       = '0;

    arpc_chain u_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .tok_first (tok_first),
        .tok_last  (tok_last)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = (walk_op_in == WALK_NONE) ? ST_FIN : ST_WALK;
                end
            end
            ST_WALK: begin
                if (tok_last.active) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (fin_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            inject_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
            tick_count_reg <= '0;
            local_ip_reg   <= '0;
            local_mac_reg  <= '0;
            age_limit_reg  <= AGE_LIMIT_RESET;
        end else begin
            state_reg  <= state_next;
            inject_reg <= in_fire && (walk_op_in != WALK_NONE);
            if (fin_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (tick_go) begin
                tick_count_reg <= tick_count_reg + 32'd1;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_LOCAL_IP:  local_ip_reg  <= cfg_wdata[31:0];
                    CFG_LOCAL_MAC: local_mac_reg <= cfg_wdata;
                    CFG_AGE_LIMIT: age_limit_reg <= cfg_wdata[31:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // request latch and walk outcome
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            kind_reg      <= s_kind;
            opcode_reg    <= s_opcode;
            src_ip_reg    <= s_src_ip;
            src_mac_reg   <= s_src_mac;
            tgt_ip_reg    <= s_tgt_ip;
            port_reg      <= s_in_port;
            key_ip_reg    <= do_learn ? s_src_ip : s_query_ip;
            walk_op_reg   <= walk_op_in;
            found_reg     <= 1'b0;
            free_seen_reg <= 1'b0;
            found_mac_reg <= '0;
        end else if ((state_reg == ST_WALK) && tok_last.active) begin
            found_reg     <= tok_last.found;
            free_seen_reg <= tok_last.free_seen;
            found_mac_reg <= tok_last.mac;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (fin_go) begin
            reply_valid_reg   <= reply_now;
            reply_dst_mac_reg <= reply_now ? src_mac_reg : '0;
            reply_dst_ip_reg  <= reply_now ? src_ip_reg : '0;
            reply_port_reg    <= reply_now ? port_reg : '0;
            lookup_hit_reg    <= (walk_op_reg == WALK_LOOKUP) && found_reg;
            hit_mac_reg       <= ((walk_op_reg == WALK_LOOKUP) && found_reg)
                                 ? found_mac_reg : '0;
            learn_dropped_reg <= (walk_op_reg == WALK_LEARN) && !found_reg
                                 && !free_seen_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_reply_valid   = reply_valid_reg;
    assign m_reply_dst_mac = reply_dst_mac_reg;
    assign m_reply_dst_ip  = reply_dst_ip_reg;
    assign m_reply_port    = reply_port_reg;
    assign m_lookup_hit    = lookup_hit_reg;
    assign m_hit_mac       = hit_mac_reg;
    assign m_learn_dropped = learn_dropped_reg;

    assign hit_out = m_valid && m_lookup_hit;

    // token leaves the row only while a walk is in progress
    `ARPC_ASSERT_IMPLIES(a_tok_in_walk, aclk, aresetn, tok_last.active, state_reg == ST_WALK)

    // a slot is only committed after a learn walk that found a free slot and no match
    `ARPC_ASSERT_IMPLIES(a_commit_ok, aclk, aresetn, cmd.commit, free_seen_reg && !found_reg)

    // tick counter moves only when a tick request completes
    `ARPC_ASSERT_NEXT(a_tick_only, aclk, aresetn, !tick_go, $stable(tick_count_reg))

    // a lookup hit never carries reply or drop flags
    `ARPC_ASSERT_IMPLIES(a_hit_excl, aclk, aresetn, hit_out, !m_reply_valid && !m_learn_dropped)

endmodule

`default_nettype wire
